FILE: hw/rtl/sliding_window_line_fit_macros.svh
// assertion helpers, clock clk and reset arst_n taken from the enclosing module
`ifndef SLIDING_WINDOW_LINE_FIT_MACROS_SVH
`define SLIDING_WINDOW_LINE_FIT_MACROS_SVH

// same-cycle implication
`define SWLF_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWLF_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/swlf_pkg.sv
`default_nettype none
package swlf_pkg;
	localparam int MAX_WINDOW  = 1024;
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W       = IDX_W + 1;
	localparam int CFG_W       = 11;
	localparam int WL_RESET    = 1000;
	localparam int FUNC_W      = 2;
	localparam int SAMPLE_BITS = 16;
	localparam int OFF_W       = SAMPLE_BITS + 1;
	localparam int FRAC_BITS   = 16;
	localparam int SUM_W       = 28;
	localparam int SQ_W        = 45;
	localparam int RES_W       = 32;
	// working width of products, numerator and denominator
	localparam int DW          = 60;
	localparam int MB_W        = 32;
	localparam int QW          = DW + FRAC_BITS;
	localparam int ADD_W       = DW + 2;
	localparam int STEP_W      = $clog2(QW + 1);

	localparam logic signed [DW-1:0] SAT_HI = DW'(64'sh7fff_ffff);
	localparam logic signed [DW-1:0] SAT_LO = DW'(-64'sh8000_0000);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_EVAL   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	function automatic logic signed [RES_W-1:0] sat32(input logic signed [DW-1:0] v);
		logic signed [RES_W-1:0] r;
		if (v > SAT_HI) begin
			r = RES_W'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = RES_W'(SAT_LO);
		end else begin
			r = RES_W'(v);
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] abs_dw(input logic signed [DW-1:0] v);
		logic [DW-1:0] r;
		if (v[DW-1]) begin
			r = DW'(-v);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/swlf_if.sv
`default_nettype none
interface swlf_in_if import swlf_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [FUNC_W-1:0]             func;
	logic signed [SAMPLE_BITS-1:0] x_value;
	logic signed [SAMPLE_BITS-1:0] y_value;

	modport source(output valid, func, x_value, y_value, input ready);
	modport sink(input valid, func, x_value, y_value, output ready);
endinterface

interface swlf_out_if import swlf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    fit_valid;
	logic signed [RES_W-1:0] gradient;
	logic signed [RES_W-1:0] intercept;
	logic signed [RES_W-1:0] estimate;
	logic [CNT_W-1:0]        point_count;

	modport source(output valid, fit_valid, gradient, intercept, estimate, point_count,
		input ready);
	modport sink(input valid, fit_valid, gradient, intercept, estimate, point_count,
		output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sliding_window_line_fit.sv
// channel  dir  handshake      word
// req      in   valid/ready    func, x_value, y_value
// rsp      out  valid/ready    fit_valid, gradient, intercept, estimate, point_count
// cfg      in   cfg_wr_en      cfg_wr_data (window_len)
//
// one word at a time; req.ready only while the sequencer idles
// products take one step per multiplier bit and quotients one per quotient bit of the
// shared adder unit, which each point added or dropped and each fit with two or more
// points use; a zero denominator ends the fit before the divides
// a finished word waits in the rsp register while the next req word is taken
// reset is asynchronous; the point ring needs no clearing pass
`default_nettype none
`include "sliding_window_line_fit_macros.svh"
module sliding_window_line_fit import swlf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	swlf_in_if.sink          req,
	swlf_out_if.source       rsp
);
	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_DROP_RD = 17'h00002,
		S_DROP_LD = 17'h00004,
		S_WRITE   = 17'h00008,
		S_XX      = 17'h00010,
		S_XY      = 17'h00020,
		S_FIT     = 17'h00040,
		S_NUM1    = 17'h00080,
		S_NUM2    = 17'h00100,
		S_DEN1    = 17'h00200,
		S_DEN2    = 17'h00400,
		S_GDIV    = 17'h00800,
		S_C0M     = 17'h01000,
		S_C0D     = 17'h02000,
		S_CI      = 17'h04000,
		S_EST     = 17'h08000,
		S_OUT     = 17'h10000
	} state_t;

	// control and window state
	state_t                        state_q;
	logic [CFG_W-1:0]              window_len_q;
	logic [IDX_W-1:0]              oldest_q;
	logic [CNT_W-1:0]              count_q;
	logic signed [SUM_W-1:0]       sum_x_q;
	logic signed [SUM_W-1:0]       sum_y_q;
	logic signed [SQ_W-1:0]        sum_xx_q;
	logic signed [SQ_W-1:0]        sum_xy_q;
	logic signed [SAMPLE_BITS-1:0] origin_x_q;
	logic signed [SAMPLE_BITS-1:0] origin_y_q;
	logic                          issued_q;
	logic                          pre_q;
	logic                          dropped_q;
	logic                          ins_q;
	logic                          out_valid_q;

	// datapath
	logic signed [OFF_W-1:0]       nx_q;
	logic signed [OFF_W-1:0]       ny_q;
	logic signed [OFF_W:0]         pa_x_q;
	logic signed [OFF_W-1:0]       pb_x_q;
	logic signed [OFF_W-1:0]       pb_y_q;
	logic signed [SAMPLE_BITS-1:0] xq_q;
	logic signed [DW-1:0]          tmp_q;
	logic signed [DW-1:0]          num_q;
	logic signed [DW-1:0]          den_q;
	logic signed [RES_W-1:0]       m_q;
	logic signed [RES_W-1:0]       ci_q;
	logic signed [RES_W-1:0]       est_q;
	logic                          fit_ok_q;
	logic                          o_fit_q;
	logic signed [RES_W-1:0]       o_grad_q;
	logic signed [RES_W-1:0]       o_icpt_q;
	logic signed [RES_W-1:0]       o_est_q;
	logic [CNT_W-1:0]              o_cnt_q;

	logic                          in_acc;
	logic                          out_load;
	logic                          first_pt;
	logic                          ring_full;
	logic signed [SAMPLE_BITS-1:0] org_x;
	logic signed [SAMPLE_BITS-1:0] org_y;
	logic signed [OFF_W-1:0]       dx;
	logic signed [OFF_W-1:0]       dy;
	logic [2*OFF_W-1:0]            ram_rdata;
	logic signed [OFF_W-1:0]       rd_x;
	logic signed [OFF_W-1:0]       rd_y;
	logic                          arith_st;
	logic                          div_st;
	logic                          den_zero;
	logic signed [MB_W-1:0]        cnt_m;
	logic signed [MB_W-1:0]        nsx_m;

	// shared unit operands
	unit_cmd_t                     u_cmd;
	unit_sts_t                     u_sts;
	logic signed [DW-1:0]          op_acc;
	logic signed [DW-1:0]          op_mcand;
	logic [MB_W-1:0]               op_mplier;
	logic [QW-1:0]                 op_dvd;
	logic [DW-1:0]                 op_dvs;
	logic signed [DW-1:0]          u_prod;
	logic [QW-1:0]                 u_quot;

	// gradient and intercept post-processing
	logic                          g_neg;
	logic                          g_ovf;
	logic [RES_W-1:0]              g_lim;
	logic [RES_W-1:0]              g_low;
	logic [RES_W-1:0]              g_mag;
	logic signed [RES_W-1:0]       g_m;
	logic signed [DW-1:0]          c0;
	logic signed [DW-1:0]          ci_pre;

	assign req.ready = (state_q == S_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	// first point into an empty window becomes the origin
	assign first_pt  = (count_q == '0);
	assign ring_full = (count_q >= CNT_W'(MAX_WINDOW));
	assign org_x     = first_pt ? req.x_value : origin_x_q;
	assign org_y     = first_pt ? req.y_value : origin_y_q;
	assign dx        = OFF_W'(req.x_value) - OFF_W'(org_x);
	assign dy        = OFF_W'(req.y_value) - OFF_W'(org_y);

	assign rd_x = ram_rdata[2*OFF_W-1:OFF_W];
	assign rd_y = ram_rdata[OFF_W-1:0];

	assign arith_st = (state_q == S_XX) || (state_q == S_XY) || (state_q == S_NUM1) ||
		(state_q == S_NUM2) || (state_q == S_DEN1) || (state_q == S_DEN2) ||
		(state_q == S_GDIV) || (state_q == S_C0M) || (state_q == S_C0D) ||
		(state_q == S_CI) || (state_q == S_EST);
	assign div_st   = (state_q == S_GDIV) || (state_q == S_C0D);
	assign den_zero = (den_q == '0);

	assign u_cmd.start = arith_st && !issued_q && !((state_q == S_GDIV) && den_zero);
	assign u_cmd.op    = div_st ? OP_DIV : OP_MUL;

	assign cnt_m = MB_W'(signed'({1'b0, count_q}));
	assign nsx_m = -(MB_W'(sum_x_q));

	// operand selection per step
	always_comb begin
		op_acc    = '0;
		op_mcand  = '0;
		op_mplier = '0;
		op_dvd    = '0;
		op_dvs    = '0;
		unique case (state_q)
			S_XX: begin
				op_acc    = DW'(sum_xx_q);
				op_mcand  = DW'(pa_x_q);
				op_mplier = MB_W'(pb_x_q);
			end
			S_XY: begin
				op_acc    = DW'(sum_xy_q);
				op_mcand  = DW'(pa_x_q);
				op_mplier = MB_W'(pb_y_q);
			end
			S_NUM1: begin
				op_mcand  = DW'(sum_xy_q);
				op_mplier = cnt_m;
			end
			S_NUM2: begin
				op_acc    = tmp_q;
				op_mcand  = DW'(sum_y_q);
				op_mplier = nsx_m;
			end
			S_DEN1: begin
				op_mcand  = DW'(sum_xx_q);
				op_mplier = cnt_m;
			end
			S_DEN2: begin
				op_acc    = tmp_q;
				op_mcand  = DW'(sum_x_q);
				op_mplier = nsx_m;
			end
			S_GDIV: begin
				op_dvd = {abs_dw(num_q), {FRAC_BITS{1'b0}}};
				op_dvs = abs_dw(den_q);
			end
			S_C0M: begin
				op_acc    = DW'(sum_y_q) <<< FRAC_BITS;
				op_mcand  = -(DW'(sum_x_q));
				op_mplier = m_q;
			end
			S_C0D: begin
				op_dvd = QW'(abs_dw(tmp_q));
				op_dvs = DW'(count_q);
			end
			S_CI: begin
				op_acc    = tmp_q;
				op_mcand  = -(DW'(origin_x_q));
				op_mplier = m_q;
			end
			S_EST: begin
				op_acc    = DW'(ci_q);
				op_mcand  = DW'(xq_q);
				op_mplier = m_q;
			end
			default: begin
				op_acc = '0;
			end
		endcase
	end

	// slope: truncated quotient, clipped to the q16.16 range
	always_comb begin
		g_neg = num_q[DW-1] ^ den_q[DW-1];
		g_ovf = |u_quot[QW-1:RES_W];
		g_lim = g_neg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
		g_low = u_quot[RES_W-1:0];
		g_mag = (g_ovf || (g_low > g_lim)) ? g_lim : g_low;
		g_m   = g_neg ? -signed'(g_mag) : signed'(g_mag);
	end

	// intercept term: signed quotient by n, then back to original coordinates
	assign c0     = tmp_q[DW-1] ? -signed'(u_quot[DW-1:0]) : signed'(u_quot[DW-1:0]);
	assign ci_pre = c0 + (DW'(origin_y_q) <<< FRAC_BITS);

	swlf_unit u_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (u_cmd),
		.sts      (u_sts),
		.acc_init (op_acc),
		.mcand    (op_mcand),
		.mplier   (op_mplier),
		.dividend (op_dvd),
		.divisor  (op_dvs),
		.prod     (u_prod),
		.quot     (u_quot)
	);

	// point ring: x offset in the upper half, y offset in the lower half
	swlf_ram #(
		.WIDTH (2 * OFF_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_WRITE),
		.waddr (oldest_q + count_q[IDX_W-1:0]),
		.wdata ({nx_q, ny_q}),
		.re    (state_q == S_DROP_RD),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			window_len_q <= CFG_W'(WL_RESET);
			oldest_q     <= '0;
			count_q      <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			sum_xx_q     <= '0;
			sum_xy_q     <= '0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			issued_q     <= 1'b0;
			pre_q        <= 1'b0;
			dropped_q    <= 1'b0;
			ins_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				window_len_q <= cfg_wr_data;
			end
			// a new word may replace the one leaving in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (u_sts.done) begin
				issued_q <= 1'b0;
			end else if (u_cmd.start) begin
				issued_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (req.func)
							FUNC_INSERT: begin
								if (first_pt) begin
									origin_x_q <= req.x_value;
									origin_y_q <= req.y_value;
									oldest_q   <= '0;
								end
								// full ring drops its oldest point before the write
								pre_q     <= ring_full;
								dropped_q <= ring_full;
								state_q   <= ring_full ? S_DROP_RD : S_WRITE;
							end
							FUNC_CLEAR: begin
								oldest_q   <= '0;
								count_q    <= '0;
								sum_x_q    <= '0;
								sum_y_q    <= '0;
								sum_xx_q   <= '0;
								sum_xy_q   <= '0;
								origin_x_q <= '0;
								origin_y_q <= '0;
								state_q    <= S_FIT;
							end
							FUNC_EVAL: begin
								state_q <= S_FIT;
							end
							default: begin
								state_q <= S_FIT;
							end
						endcase
					end
				end
				S_DROP_RD: begin
					state_q <= S_DROP_LD;
				end
				S_DROP_LD: begin
					sum_x_q  <= sum_x_q - SUM_W'(rd_x);
					sum_y_q  <= sum_y_q - SUM_W'(rd_y);
					oldest_q <= oldest_q + IDX_W'(1);
					count_q  <= count_q - CNT_W'(1);
					ins_q    <= 1'b0;
					state_q  <= S_XX;
				end
				S_WRITE: begin
					sum_x_q <= sum_x_q + SUM_W'(nx_q);
					sum_y_q <= sum_y_q + SUM_W'(ny_q);
					count_q <= count_q + CNT_W'(1);
					ins_q   <= 1'b1;
					state_q <= S_XX;
				end
				S_XX: begin
					if (u_sts.done) begin
						sum_xx_q <= SQ_W'(u_prod);
						state_q  <= S_XY;
					end
				end
				S_XY: begin
					if (u_sts.done) begin
						sum_xy_q <= SQ_W'(u_prod);
						if (ins_q) begin
							// over the window length: drop one oldest point
							if (!dropped_q && (count_q > window_len_q)) begin
								state_q <= S_DROP_RD;
							end else begin
								state_q <= S_FIT;
							end
						end else if (pre_q) begin
							pre_q   <= 1'b0;
							state_q <= S_WRITE;
						end else begin
							state_q <= S_FIT;
						end
					end
				end
				S_FIT: begin
					state_q <= (count_q < CNT_W'(2)) ? S_OUT : S_NUM1;
				end
				S_NUM1: begin
					if (u_sts.done) begin
						state_q <= S_NUM2;
					end
				end
				S_NUM2: begin
					if (u_sts.done) begin
						state_q <= S_DEN1;
					end
				end
				S_DEN1: begin
					if (u_sts.done) begin
						state_q <= S_DEN2;
					end
				end
				S_DEN2: begin
					if (u_sts.done) begin
						state_q <= S_GDIV;
					end
				end
				S_GDIV: begin
					// degenerate x spread: no fit
					if (den_zero) begin
						state_q <= S_OUT;
					end else if (u_sts.done) begin
						state_q <= S_C0M;
					end
				end
				S_C0M: begin
					if (u_sts.done) begin
						state_q <= S_C0D;
					end
				end
				S_C0D: begin
					if (u_sts.done) begin
						state_q <= S_CI;
					end
				end
				S_CI: begin
					if (u_sts.done) begin
						state_q <= S_EST;
					end
				end
				S_EST: begin
					if (u_sts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		if (in_acc) begin
			xq_q <= req.x_value;
			nx_q <= dx;
			ny_q <= dy;
		end
		if (state_q == S_DROP_LD) begin
			pa_x_q <= -((OFF_W + 1)'(rd_x));
			pb_x_q <= rd_x;
			pb_y_q <= rd_y;
		end
		if (state_q == S_WRITE) begin
			pa_x_q <= (OFF_W + 1)'(nx_q);
			pb_x_q <= nx_q;
			pb_y_q <= ny_q;
		end
		if (state_q == S_FIT) begin
			fit_ok_q <= 1'b0;
		end
		if (u_sts.done) begin
			if ((state_q == S_NUM1) || (state_q == S_DEN1) || (state_q == S_C0M)) begin
				tmp_q <= u_prod;
			end
			if (state_q == S_NUM2) begin
				num_q <= u_prod;
			end
			if (state_q == S_DEN2) begin
				den_q <= u_prod;
			end
			if (state_q == S_GDIV) begin
				m_q <= g_m;
			end
			if (state_q == S_C0D) begin
				tmp_q <= ci_pre;
			end
			if (state_q == S_CI) begin
				ci_q <= sat32(u_prod);
			end
			if (state_q == S_EST) begin
				est_q    <= sat32(u_prod);
				fit_ok_q <= 1'b1;
			end
		end
		if (out_load) begin
			o_fit_q  <= fit_ok_q;
			o_grad_q <= fit_ok_q ? m_q : '0;
			o_icpt_q <= fit_ok_q ? ci_q : '0;
			o_est_q  <= fit_ok_q ? est_q : '0;
			o_cnt_q  <= count_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.fit_valid   = o_fit_q;
	assign rsp.gradient    = o_grad_q;
	assign rsp.intercept   = o_icpt_q;
	assign rsp.estimate    = o_est_q;
	assign rsp.point_count = o_cnt_q;

	`SWLF_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_WINDOW), "count above ring depth")
	`SWLF_ASSERT_IMP(a_start_idle, u_cmd.start, !u_sts.busy, "unit started while busy")
	`SWLF_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE, "word taken but idle")
	`SWLF_ASSERT_IMP(a_fit_two_pts, rsp.valid && rsp.fit_valid,
		rsp.point_count >= CNT_W'(2), "fit flagged with fewer than two points")
endmodule
`default_nettype wire

FILE: hw/rtl/swlf_ram.sv
`default_nettype none
module swlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/swlf_unit.sv
`default_nettype none
module swlf_unit import swlf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  unit_cmd_t            cmd,
	output unit_sts_t            sts,
	input  logic signed [DW-1:0] acc_init,
	input  logic signed [DW-1:0] mcand,
	input  logic [MB_W-1:0]      mplier,
	input  logic [QW-1:0]        dividend,
	input  logic [DW-1:0]        divisor,
	output logic signed [DW-1:0] prod,
	output logic [QW-1:0]        quot
);
	logic                 busy_q;
	logic                 done_q;
	op_t                  op_q;
	logic [STEP_W-1:0]    step_q;
	logic signed [DW-1:0] acc_q;
	logic signed [DW-1:0] md_q;
	logic [MB_W-1:0]      mr_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        dvs_q;
	logic [QW-1:0]        dq_q;

	logic [ADD_W-1:0] add_a;
	logic [ADD_W-1:0] add_b;
	logic [ADD_W-1:0] add_s;
	logic             add_sub;
	logic             last;

	// one adder: shift-add multiply or restoring divide
	always_comb begin
		unique case (op_q)
			OP_MUL: begin
				add_a   = ADD_W'(acc_q);
				add_b   = ADD_W'(md_q);
				// top multiplier bit carries negative weight
				add_sub = (step_q == STEP_W'(MB_W - 1));
				last    = (step_q == STEP_W'(MB_W - 1));
			end
			OP_DIV: begin
				add_a   = {1'b0, rem_q, dq_q[QW-1]};
				add_b   = {2'b00, dvs_q};
				add_sub = 1'b1;
				last    = (step_q == STEP_W'(QW - 1));
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
				last    = 1'b1;
			end
		endcase
		add_s = add_a + (add_b ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= acc_init;
			md_q  <= mcand;
			mr_q  <= mplier;
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					if (mr_q[0]) begin
						acc_q <= add_s[DW-1:0];
					end
					md_q <= md_q <<< 1;
					mr_q <= mr_q >> 1;
				end
				OP_DIV: begin
					rem_q <= add_s[ADD_W-1] ? add_a[DW-1:0] : add_s[DW-1:0];
					dq_q  <= {dq_q[QW-2:0], ~add_s[ADD_W-1]};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign prod     = acc_q;
	assign quot     = dq_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule
`default_nettype wire

FILE: test/tb_sliding_window_line_fit.sv
`default_nettype none
module tb_sliding_window_line_fit;
	import swlf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// func code 3 is unused by the block and behaves as evaluate
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int RING = MAX_WINDOW;
	localparam int OWED_DEPTH = 16;
	localparam longint Q_ONE = 64'sd65536;
	localparam longint POS_LIM = 64'sd2147483647;
	localparam longint NEG_LIM = -64'sd2147483648;

	typedef struct {
		logic                    fit_valid;
		logic signed [RES_W-1:0] gradient;
		logic signed [RES_W-1:0] intercept;
		logic signed [RES_W-1:0] estimate;
		logic [CNT_W-1:0]        point_count;
	} fit_word_t;

	// one row of the directed table; known marks rows whose result is typed in
	typedef struct {
		logic [FUNC_W-1:0]             func;
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [SAMPLE_BITS-1:0] y;
		bit                            known;
		fit_word_t                     res;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	swlf_in_if  req_if();
	swlf_out_if rsp_if();

	sliding_window_line_fit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_if),
		.rsp        (rsp_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state: the window as offsets from its origin, plus running sums
	int      ring_x [RING];
	int      ring_y [RING];
	int      head;
	int      held;
	int      win_len;
	longint  s_x, s_y, s_xx, s_xy, org_x, org_y;

	// results owed by the block, in order of acceptance
	fit_word_t owed_fits [OWED_DEPTH];
	int        owed_wr = 0;
	int        owed_rd = 0;
	int        errors = 0;
	int        words_sent = 0;
	int        send_idle = 10;
	int        recv_idle = 49;
	bit        hold_rsp = 1'b0;

	// line used to shape random points: y = slope*x + offset + jitter
	int line_slope, line_off, line_jit, x_lo, x_hi;

	function automatic longint clamp32(longint v);
		if (v > POS_LIM) return POS_LIM;
		if (v < NEG_LIM) return NEG_LIM;
		return v;
	endfunction

	function automatic void window_clear();
		head = 0;
		held = 0;
		s_x = 0; s_y = 0; s_xx = 0; s_xy = 0;
		org_x = 0; org_y = 0;
	endfunction

	function automatic void drop_oldest_point();
		longint dx, dy;
		if (held == 0) return;
		dx = ring_x[head];
		dy = ring_y[head];
		s_x -= dx;
		s_y -= dy;
		s_xx -= dx * dx;
		s_xy -= dx * dy;
		head = (head + 1) % RING;
		held--;
	endfunction

	function automatic void add_point(longint xv, longint yv);
		longint dx, dy;
		int pos;
		bit dropped;
		dropped = 1'b0;
		// the first point into an empty window becomes the origin
		if (held == 0) begin
			org_x = xv;
			org_y = yv;
			head = 0;
		end
		dx = xv - org_x;
		dy = yv - org_y;
		if (held >= RING) begin
			drop_oldest_point();
			dropped = 1'b1;
		end
		pos = (head + held) % RING;
		ring_x[pos] = int'(dx);
		ring_y[pos] = int'(dy);
		s_x += dx;
		s_y += dy;
		s_xx += dx * dx;
		s_xy += dx * dy;
		held++;
		// over-full after a config shrink still drops only one point per insert
		if (!dropped && held > win_len) drop_oldest_point();
	endfunction

	function automatic fit_word_t fit_at(longint xq);
		fit_word_t r;
		longint n, num, den, m, c0, ci;
		longint unsigned an, ad, qi, rem, lim, mag;
		bit neg;
		r.fit_valid = 1'b0;
		r.gradient = '0;
		r.intercept = '0;
		r.estimate = '0;
		r.point_count = CNT_W'(held);
		n = held;
		if (n < 2) return r;
		num = n * s_xy - s_y * s_x;
		den = n * s_xx - s_x * s_x;
		if (den == 0) return r;
		neg = (num < 0) ^ (den < 0);
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		qi = an / ad;
		rem = an % ad;
		if (qi > (lim >> FRAC_BITS)) begin
			mag = lim;
		end else begin
			// restoring division for the fraction bits, quotient truncated
			for (int i = 0; i < FRAC_BITS; i++) begin
				qi <<= 1;
				if (rem >= ad - rem) begin
					rem -= ad - rem;
					qi |= 1;
				end else begin
					rem <<= 1;
				end
			end
			mag = (qi > lim) ? lim : qi;
		end
		m = neg ? -longint'(mag) : longint'(mag);
		c0 = (s_y * Q_ONE - m * s_x) / n;
		ci = clamp32(c0 + org_y * Q_ONE - m * org_x);
		r.fit_valid = 1'b1;
		r.gradient = RES_W'(m);
		r.intercept = RES_W'(ci);
		r.estimate = RES_W'(clamp32(m * xq + ci));
		return r;
	endfunction

	function automatic fit_word_t apply_word(logic [FUNC_W-1:0] f, longint xv, longint yv);
		if (f == FUNC_INSERT) add_point(xv, yv);
		else if (f == FUNC_CLEAR) window_clear();
		return fit_at(xv);
	endfunction

	// offer one word, wait for the handshake, then record what it should return;
	// valid stays high on return so back-to-back words need no second assignment
	task automatic send_word(logic [FUNC_W-1:0] f, logic signed [SAMPLE_BITS-1:0] xv,
			logic signed [SAMPLE_BITS-1:0] yv, bit known, fit_word_t typed);
		fit_word_t exp;
		while ($urandom_range(99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= f;
		req_if.x_value <= xv;
		req_if.y_value <= yv;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		exp = apply_word(f, xv, yv);
		owed_fits[owed_wr % OWED_DEPTH] = known ? typed : exp;
		owed_wr++;
		words_sent++;
		// idling pattern moves through its three phases as words go by
		if (words_sent == 480) begin
			send_idle = 49;
			recv_idle = 10;
		end else if (words_sent == 960) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	// register writes only with the block idle: no word in flight, no result owed
	task automatic write_window_len(int len);
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (owed_wr != owed_rd) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CFG_W'(len);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_len = len;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] to_sample(int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return -16'sh8000;
		return SAMPLE_BITS'(v);
	endfunction

	function automatic void new_line();
		int span;
		line_slope = $urandom_range(16) - 8;
		line_off = $urandom_range(4000) - 2000;
		line_jit = $urandom_range(3) == 0 ? 0 : $urandom_range(200);
		span = ($urandom_range(3) == 0) ? 32767 : $urandom_range(3000);
		x_lo = $urandom_range(span) - span / 2 - 1;
		x_hi = x_lo + $urandom_range(span);
		if (x_hi > 32767) x_hi = 32767;
	endfunction

	// mostly points near a line with random content, some noise over full range
	task automatic random_words(int count, int pct_insert, int pct_clear);
		int r, xi;
		logic [FUNC_W-1:0] f;
		logic signed [SAMPLE_BITS-1:0] xv, yv;
		fit_word_t none;
		none = '{default: '0};
		new_line();
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < pct_insert) f = FUNC_INSERT;
			else if (r < pct_insert + pct_clear) f = FUNC_CLEAR;
			else if (r < pct_insert + pct_clear + 3) f = FUNC_SPARE;
			else f = FUNC_EVAL;
			if (f == FUNC_CLEAR || $urandom_range(39) == 0) new_line();
			if ($urandom_range(9) == 0) begin
				xv = SAMPLE_BITS'($urandom);
				yv = SAMPLE_BITS'($urandom);
			end else begin
				xi = x_lo + $urandom_range(x_hi - x_lo);
				xv = to_sample(xi);
				yv = to_sample(line_slope * xi + line_off
					+ int'($urandom_range(2 * line_jit)) - line_jit);
			end
			// one long receiver hold so the result register fills and input stalls
			if (words_sent == 300) hold_rsp = 1'b1;
			send_word(f, xv, yv, 1'b0, none);
		end
	endtask

	// receiver: random back-pressure, plus the single long hold-off
	initial begin
		int hold_cnt;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_if.ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < 2000; hold_cnt++) @(posedge clk);
			end
			rsp_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// result checker: each word against the oldest owed fit
	always @(posedge clk) begin
		fit_word_t exp;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (owed_wr == owed_rd) begin
				$display("%t unexpected result word, count %0d", $realtime,
					rsp_if.point_count);
				errors++;
			end else begin
				exp = owed_fits[owed_rd % OWED_DEPTH];
				owed_rd++;
				if (rsp_if.fit_valid !== exp.fit_valid) begin
					$display("%t fit_valid exp %0d got %0d", $realtime, exp.fit_valid,
						rsp_if.fit_valid);
					errors++;
				end
				if (rsp_if.gradient !== exp.gradient) begin
					$display("%t gradient exp %0d got %0d", $realtime, exp.gradient,
						rsp_if.gradient);
					errors++;
				end
				if (rsp_if.intercept !== exp.intercept) begin
					$display("%t intercept exp %0d got %0d", $realtime, exp.intercept,
						rsp_if.intercept);
					errors++;
				end
				if (rsp_if.estimate !== exp.estimate) begin
					$display("%t estimate exp %0d got %0d", $realtime, exp.estimate,
						rsp_if.estimate);
					errors++;
				end
				if (rsp_if.point_count !== exp.point_count) begin
					$display("%t point_count exp %0d got %0d", $realtime,
						exp.point_count, rsp_if.point_count);
					errors++;
				end
			end
		end
	end

	initial begin
		directed_row_t rows[$];
		fit_word_t z;
		z = '{default: '0};
		req_if.valid <= 1'b0;
		req_if.func <= FUNC_EVAL;
		req_if.x_value <= '0;
		req_if.y_value <= '0;
		win_len = WL_RESET;
		window_clear();

		// directed: empty window, degenerate x, unit slope, extremes, spare code
		rows = '{
			'{FUNC_EVAL,   16'sd5,      16'sd9,      1, z},
			'{FUNC_INSERT, 16'sd0,      16'sd0,      1, '{0, 0, 0, 0, 11'd1}},
			'{FUNC_INSERT, 16'sd0,      16'sd7,      1, '{0, 0, 0, 0, 11'd2}},
			'{FUNC_CLEAR,  16'sd3,      16'sd3,      1, z},
			'{FUNC_INSERT, 16'sd0,      16'sd0,      1, '{0, 0, 0, 0, 11'd1}},
			'{FUNC_INSERT, 16'sd1,      16'sd1,      1, '{1, 65536, 0, 65536, 11'd2}},
			'{FUNC_EVAL,   16'sd2,      16'sd0,      0, z},
			'{FUNC_CLEAR,  16'sd0,      16'sd0,      1, z},
			'{FUNC_INSERT, -16'sd32768, -16'sd32768, 0, z},
			'{FUNC_INSERT, 16'sd32767,  16'sd32767,  1,
				'{1, 65536, 0, 32'sh7fff_0000, 11'd2}},
			'{FUNC_SPARE,  -16'sd32768, 16'sd1,      1,
				'{1, 65536, 0, 32'sh8000_0000, 11'd2}},
			'{FUNC_INSERT, 16'sd32767,  -16'sd32768, 0, z},
			'{FUNC_EVAL,   16'sd0,      16'sd0,      0, z},
			'{FUNC_CLEAR,  16'sd0,      16'sd0,      1, z},
			'{FUNC_INSERT, 16'sd0,      -16'sd32768, 0, z},
			'{FUNC_INSERT, 16'sd1,      16'sd32767,  0, z},
			'{FUNC_EVAL,   16'sd32767,  16'sd0,      0, z},
			'{FUNC_INSERT, -16'sd1,     16'sd32767,  0, z},
			'{FUNC_SPARE,  -16'sd32768, -16'sd1,     0, z},
			'{FUNC_CLEAR,  16'sd0,      16'sd0,      1, z}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_word(rows[i].func, rows[i].x, rows[i].y, rows[i].known,
			rows[i].res);

		// window settings, extremes included; a window of zero keeps nothing
		write_window_len(3);
		random_words(90, 65, 6);
		write_window_len(0);
		random_words(30, 70, 5);
		write_window_len(1);
		random_words(30, 70, 5);
		write_window_len(2);
		random_words(60, 65, 6);
		write_window_len(1024);
		random_words(60, 65, 6);
		// longest setting: clear, then a long run of mostly inserts
		write_window_len(2047);
		send_word(FUNC_CLEAR, 16'sd0, 16'sd0, 1'b1, z);
		random_words(1030, 97, 0);
		// shrink below the points held: each insert still drops just one
		write_window_len(5);
		random_words(60, 70, 0);
		write_window_len(16);
		random_words(60, 65, 5);

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (owed_wr != owed_rd) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0) begin
			$display("tb_sliding_window_line_fit OK");
		end else begin
			$display("tb_sliding_window_line_fit NOT OK");
		end
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("tb_sliding_window_line_fit NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
